// ----- design/lmf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmf_pkg: shared types, codes and tables
// Command codes, sequencer states, gradient type and the interpolated
// sigmoid / softplus tables used by the SGD update block.
// ----------------------------------------------------------------------------
package lmf_pkg;

  // command field codes
  localparam logic [2:0] CMD_TRAIN     = 3'd0;
  localparam logic [2:0] CMD_WR_USER   = 3'd1;
  localparam logic [2:0] CMD_WR_ITEM   = 3'd2;
  localparam logic [2:0] CMD_RD_USER   = 3'd3;
  localparam logic [2:0] CMD_RD_ITEM   = 3'd4;
  localparam logic [2:0] CMD_WR_GLOBAL = 3'd5;
  localparam logic [2:0] CMD_RD_GLOBAL = 3'd6;

  // configuration register indexes
  localparam logic CFG_RATE  = 1'b0;
  localparam logic CFG_DECAY = 1'b1;

  localparam logic [15:0] RATE_RESET  = 16'd655;
  localparam logic [15:0] DECAY_RESET = 16'd0;

  // gradient in signed Q1.16, range -1.0 .. +1.0
  localparam int GW = 18;
  typedef logic signed [GW-1:0] grad_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TRAIN,
    OP_WR_USER,
    OP_WR_ITEM,
    OP_RD_USER,
    OP_RD_ITEM,
    OP_WR_GLOBAL,
    OP_RD_GLOBAL
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_DOT_RD,
    ST_DOT_WAIT,
    ST_SCORE,
    ST_SIG,
    ST_UPD_RD,
    ST_UPD_DRAIN,
    ST_DONE
  } state_e;

  function automatic logic [15:0] sig_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47910;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] lse_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd45426;
      5'd1:    v = 16'd31069;
      5'd2:    v = 16'd20530;
      5'd3:    v = 16'd13200;
      5'd4:    v = 16'd8318;
      5'd5:    v = 16'd5170;
      5'd6:    v = 16'd3184;
      5'd7:    v = 16'd1950;
      5'd8:    v = 16'd1189;
      5'd9:    v = 16'd724;
      5'd10:   v = 16'd440;
      5'd11:   v = 16'd267;
      5'd12:   v = 16'd162;
      5'd13:   v = 16'd98;
      5'd14:   v = 16'd60;
      5'd15:   v = 16'd36;
      default: v = 16'd22;
    endcase
    return v;
  endfunction

  // linear interpolation over half-unit steps, floor; a is |x| in Q.12
  function automatic logic [15:0] interp(input logic use_lse, input logic [40:0] a);
    logic [3:0]  k;
    logic [10:0] f;
    logic [15:0] t0;
    logic [15:0] t1;
    logic [28:0] s;
    logic [15:0] r;
    k  = a[14:11];
    f  = a[10:0];
    t0 = use_lse ? lse_tab({1'b0, k}) : sig_tab({1'b0, k});
    t1 = use_lse ? lse_tab(5'({1'b0, k}) + 5'd1) : sig_tab(5'({1'b0, k}) + 5'd1);
    s  = 29'(t0) * 29'(12'd2048 - 12'(f)) + 29'(t1) * 29'(f);
    if (a >= 41'd32768) begin
      r = use_lse ? lse_tab(5'd16) : sig_tab(5'd16);
    end else begin
      r = 16'(s >> 11);
    end
    return r;
  endfunction

endpackage

// ----- design/lmf_ram.sv -----
// ----------------------------------------------------------------------------
// lmf_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lmf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/lmf_upd.sv -----
// ----------------------------------------------------------------------------
// lmf_upd: regularised SGD step for one entry
// x_new = sat(x + round(rate * (grad*other - decay*x) / 2^32)), three stages.
// ----------------------------------------------------------------------------
module lmf_upd #(
  parameter int VW  = 16,
  parameter int OTW = 16,
  parameter int TW  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [TW-1:0]         tag_i,
  input  logic signed [VW-1:0]  x_i,
  input  logic signed [OTW-1:0] other_i,
  input  lmf_pkg::grad_t        grad_i,
  input  logic [15:0]           rate_i,
  input  logic [15:0]           decay_i,
  output logic                  valid_o,
  output logic [TW-1:0]         tag_o,
  output logic signed [VW-1:0]  x_o,
  output logic                  busy_o
);

  localparam int PA   = lmf_pkg::GW + OTW;
  localparam int PB   = 17 + VW;
  localparam int DW   = ((PA > PB) ? PA : PB) + 1;
  localparam int HW   = DW - 16;
  localparam int HLW  = HW + 17;
  localparam int SUMW = HLW + 1;
  localparam int DLW  = SUMW - 16;
  localparam int NW   = ((VW > DLW) ? VW : DLW) + 1;
  localparam logic signed [NW-1:0] VMAX = NW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [NW-1:0] VMIN = NW'(-(64'sd1 <<< (VW - 1)));

  logic v1_q, v2_q, v3_q;
  logic [TW-1:0] t1_q, t2_q, t3_q;
  logic signed [PA-1:0]  s1_pa_q;
  logic signed [PB-1:0]  s1_pb_q;
  logic signed [VW-1:0]  s1_x_q, s2_x_q;
  logic signed [HLW-1:0] s2_hl_q;
  logic [31:0]           s2_ll_q;
  logic signed [VW-1:0]  x_q;

  logic signed [DW-1:0]   diff;
  logic signed [HW-1:0]   hi;
  logic [15:0]            lo;
  logic [32:0]            b;
  logic signed [SUMW-1:0] sum;
  logic signed [DLW-1:0]  delta;
  logic signed [NW-1:0]   nx;
  logic signed [VW-1:0]   x_d;

  always_comb begin
    diff  = DW'(s1_pa_q) - DW'(s1_pb_q);
    hi    = HW'(diff >>> 16);
    lo    = diff[15:0];
    // round half up: bias the low product before dropping 16 bits
    b     = 33'(s2_ll_q) + 33'd2147483648;
    sum   = SUMW'(s2_hl_q) + SUMW'($signed({1'b0, b[32:16]}));
    delta = DLW'(sum >>> 16);
    nx    = NW'(s2_x_q) + NW'(delta);
    if (nx > VMAX) begin
      x_d = VW'(VMAX);
    end else if (nx < VMIN) begin
      x_d = VW'(VMIN);
    end else begin
      x_d = VW'(nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= tag_i;
    t2_q    <= t1_q;
    t3_q    <= t2_q;
    s1_pa_q <= PA'(grad_i) * PA'(other_i);
    s1_pb_q <= PB'($signed({1'b0, decay_i})) * PB'(x_i);
    s1_x_q  <= x_i;
    s2_hl_q <= HLW'(hi) * HLW'($signed({1'b0, rate_i}));
    s2_ll_q <= 32'(lo) * 32'(rate_i);
    s2_x_q  <= s1_x_q;
    x_q     <= x_d;
  end

  assign valid_o = v3_q;
  assign tag_o   = t3_q;
  assign x_o     = x_q;
  assign busy_o  = v1_q | v2_q | v3_q;

endmodule

// ----- design/logistic_mf_sgd_update.sv -----
// ----------------------------------------------------------------------------
// logistic_mf_sgd_update: logistic matrix factorisation SGD engine
// Holds user/item factor rows with their biases in two RAMs plus a global
// bias; trains on (user, item, label) and gives read/write access to entries.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o) takes one command per transfer;
//    output channel (out_valid_o / out_stall_i) returns one (loss, read_value)
//    per command, in order.
//  - Items are processed one at a time. For a train, one RAM read port per
//    table walks the row once for the dot product and once more for the
//    update.
//  - The result sits in an output register; a new command is taken while it
//    waits. A stalled receiver holds the next finished result in the engine
//    and stalls the input.
//  - After reset a clearing pass zeroes the bias entries, one row per cycle,
//    with the input stalled. Factor entries are undefined until written. APB
//    writes are taken at any time but must only change settings while the
//    engine is idle.
//  - Each row is FACTOR_DIM+1 words: factors then bias. Reads and writes of a
//    train item never touch the same word in flight, and the next command is
//    taken only after write-back has drained.
// ----------------------------------------------------------------------------
module logistic_mf_sgd_update #(
  parameter int NUM_USERS   = 4096,
  parameter int NUM_ITEMS   = 4096,
  parameter int FACTOR_DIM  = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [11:0]        user_index_i,
  input  logic [11:0]        item_index_i,
  input  logic               label_i,
  input  logic [4:0]         element_index_i,
  input  logic signed [15:0] write_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        loss_o,
  output logic signed [15:0] read_value_o
);

  localparam int VW     = VALUE_WIDTH;
  localparam int ROW    = FACTOR_DIM + 1;
  localparam int UDEPTH = NUM_USERS * ROW;
  localparam int IDEPTH = NUM_ITEMS * ROW;
  localparam int UAW    = $clog2(UDEPTH);
  localparam int IAW    = $clog2(IDEPTH);
  localparam int CW     = $clog2(FACTOR_DIM + 2);
  localparam int MAXN   = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS;
  localparam int CLW    = $clog2(MAXN);
  localparam int OTW    = (VW < 14) ? 14 : VW;

  localparam logic [CW-1:0]  K_BIAS = CW'(FACTOR_DIM);
  localparam logic [CW-1:0]  K_GLOB = CW'(FACTOR_DIM + 1);
  localparam logic [CLW-1:0] CLR_LAST = CLW'(MAXN - 1);
  localparam logic signed [32:0] VMAX = 33'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [32:0] VMIN = 33'(-(64'sd1 <<< (VW - 1)));
  localparam logic signed [63:0] DOT_LIM   = 64'sd1 <<< 61;
  localparam logic signed [63:0] SCORE_LIM = 64'sd1 <<< 40;
  localparam logic signed [OTW-1:0] BIAS_OTHER = OTW'(4096);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] rate_q, decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= lmf_pkg::RATE_RESET;
      decay_q <= lmf_pkg::DECAY_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == lmf_pkg::CFG_RATE) begin
        rate_q <= pwdata[15:0];
      end else begin
        decay_q <= pwdata[15:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lmf_pkg::CFG_DECAY) ? {16'd0, decay_q} : {16'd0, rate_q};

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  lmf_pkg::state_e state_q, state_d;
  lmf_pkg::op_e    op_q, op_d;

  logic [UAW-1:0]       ubase_q;
  logic [IAW-1:0]       ibase_q;
  logic                 label_q;
  logic [CW-1:0]        elem_q;
  logic signed [VW-1:0] wsat_q, wsat_d;
  logic [CW-1:0]        k_q;
  logic [CLW-1:0]       clr_q;
  logic                 rv_q, rupd_q, mv_q;
  logic [CW-1:0]        rk_q;
  logic signed [2*VW-1:0] prod_q;
  logic signed [63:0]   acc_q;
  logic signed [VW-1:0] ub_q, ib_q, gb_q;
  logic signed [41:0]   score_q;
  lmf_pkg::grad_t       g_q;
  logic [15:0]          res_loss_q;
  logic signed [15:0]   res_rv_q;
  logic                 out_valid_q;
  logic [15:0]          out_loss_q;
  logic signed [15:0]   out_rv_q;

  // RAM ports
  logic                 u_we, i_we;
  logic [UAW-1:0]       u_waddr, u_raddr;
  logic [IAW-1:0]       i_waddr, i_raddr;
  logic signed [VW-1:0] u_wdata, i_wdata;
  logic signed [VW-1:0] u_rdata, i_rdata;

  // update lanes
  logic                  lane_v;
  logic signed [VW-1:0]  ul_x, il_x;
  logic signed [OTW-1:0] ul_oth, il_oth;
  logic                  ul_ov, il_ov, ul_busy, il_busy;
  logic [CW-1:0]         ul_tag, il_tag;
  logic signed [VW-1:0]  ul_new, il_new;

  logic accept, load_out, rd_issue;

  assign accept   = in_valid_i && (state_q == lmf_pkg::ST_IDLE);
  assign load_out = (state_q == lmf_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // command decode
  // --------------------------------------------------------------------------
  logic uok, iok, eok;
  logic signed [32:0] wext;

  always_comb begin
    uok  = 32'(user_index_i) < NUM_USERS;
    iok  = 32'(item_index_i) < NUM_ITEMS;
    eok  = 32'(element_index_i) <= FACTOR_DIM;
    wext = 33'(write_value_i);
    if (wext > VMAX) begin
      wsat_d = VW'(VMAX);
    end else if (wext < VMIN) begin
      wsat_d = VW'(VMIN);
    end else begin
      wsat_d = VW'(wext);
    end
    case (command_i)
      lmf_pkg::CMD_TRAIN:     op_d = (uok && iok) ? lmf_pkg::OP_TRAIN : lmf_pkg::OP_NONE;
      lmf_pkg::CMD_WR_USER:   op_d = (uok && eok) ? lmf_pkg::OP_WR_USER : lmf_pkg::OP_NONE;
      lmf_pkg::CMD_WR_ITEM:   op_d = (iok && eok) ? lmf_pkg::OP_WR_ITEM : lmf_pkg::OP_NONE;
      lmf_pkg::CMD_RD_USER:   op_d = (uok && eok) ? lmf_pkg::OP_RD_USER : lmf_pkg::OP_NONE;
      lmf_pkg::CMD_RD_ITEM:   op_d = (iok && eok) ? lmf_pkg::OP_RD_ITEM : lmf_pkg::OP_NONE;
      lmf_pkg::CMD_WR_GLOBAL: op_d = lmf_pkg::OP_WR_GLOBAL;
      lmf_pkg::CMD_RD_GLOBAL: op_d = lmf_pkg::OP_RD_GLOBAL;
      default:                op_d = lmf_pkg::OP_NONE;
    endcase
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      lmf_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = lmf_pkg::ST_IDLE;
      end
      lmf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lmf_pkg::ST_EXEC;
      end
      lmf_pkg::ST_EXEC: begin
        case (op_q)
          lmf_pkg::OP_TRAIN:   state_d = lmf_pkg::ST_DOT_RD;
          lmf_pkg::OP_RD_USER: state_d = lmf_pkg::ST_RDWAIT;
          lmf_pkg::OP_RD_ITEM: state_d = lmf_pkg::ST_RDWAIT;
          default:             state_d = lmf_pkg::ST_DONE;
        endcase
      end
      lmf_pkg::ST_RDWAIT:   state_d = lmf_pkg::ST_DONE;
      lmf_pkg::ST_DOT_RD: begin
        if (k_q == K_BIAS) state_d = lmf_pkg::ST_DOT_WAIT;
      end
      lmf_pkg::ST_DOT_WAIT: begin
        if (!rv_q && !mv_q) state_d = lmf_pkg::ST_SCORE;
      end
      lmf_pkg::ST_SCORE:    state_d = lmf_pkg::ST_SIG;
      lmf_pkg::ST_SIG:      state_d = lmf_pkg::ST_UPD_RD;
      lmf_pkg::ST_UPD_RD: begin
        if (k_q == K_GLOB) state_d = lmf_pkg::ST_UPD_DRAIN;
      end
      lmf_pkg::ST_UPD_DRAIN: begin
        if (!rv_q && !ul_busy && !il_busy) state_d = lmf_pkg::ST_DONE;
      end
      lmf_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = lmf_pkg::ST_IDLE;
      end
      default: state_d = lmf_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // RAM controls
  // --------------------------------------------------------------------------
  always_comb begin
    u_we     = 1'b0;
    i_we     = 1'b0;
    u_waddr  = ubase_q + UAW'(ul_tag);
    i_waddr  = ibase_q + IAW'(il_tag);
    u_wdata  = ul_new;
    i_wdata  = il_new;
    u_raddr  = ubase_q + UAW'(elem_q);
    i_raddr  = ibase_q + IAW'(elem_q);
    rd_issue = 1'b0;
    case (state_q)
      lmf_pkg::ST_CLEAR: begin
        // bias word of row clr_q
        u_we    = 32'(clr_q) < NUM_USERS;
        i_we    = 32'(clr_q) < NUM_ITEMS;
        u_waddr = UAW'(32'(clr_q) * ROW + FACTOR_DIM);
        i_waddr = IAW'(32'(clr_q) * ROW + FACTOR_DIM);
        u_wdata = '0;
        i_wdata = '0;
      end
      lmf_pkg::ST_EXEC: begin
        u_we    = (op_q == lmf_pkg::OP_WR_USER);
        i_we    = (op_q == lmf_pkg::OP_WR_ITEM);
        u_waddr = ubase_q + UAW'(elem_q);
        i_waddr = ibase_q + IAW'(elem_q);
        u_wdata = wsat_q;
        i_wdata = wsat_q;
      end
      lmf_pkg::ST_DOT_RD, lmf_pkg::ST_UPD_RD: begin
        rd_issue = 1'b1;
        // global slot has no RAM word; re-read the bias word harmlessly
        u_raddr  = ubase_q + UAW'((k_q == K_GLOB) ? K_BIAS : k_q);
        i_raddr  = ibase_q + IAW'((k_q == K_GLOB) ? K_BIAS : k_q);
      end
      lmf_pkg::ST_UPD_DRAIN: begin
        u_we = ul_ov && (ul_tag <= K_BIAS);
        i_we = il_ov && (il_tag <= K_BIAS);
      end
      default: begin
      end
    endcase
    if (state_q == lmf_pkg::ST_UPD_RD) begin
      u_we = ul_ov && (ul_tag <= K_BIAS);
      i_we = il_ov && (il_tag <= K_BIAS);
    end
  end

  lmf_ram #(.DEPTH(UDEPTH), .WIDTH(VW)) u_user_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  lmf_ram #(.DEPTH(IDEPTH), .WIDTH(VW)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (i_wdata),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  // --------------------------------------------------------------------------
  // score, sigmoid, loss
  // --------------------------------------------------------------------------
  logic signed [63:0] acc_sum, acc_d, ssum, sclamp;
  logic signed [41:0] score_d, z;
  logic [40:0]        a;
  logic [15:0]        sigv, lsev;
  logic [16:0]        sg;
  lmf_pkg::grad_t     g_d;
  logic [37:0]        part1;
  logic [38:0]        lsum;
  logic [15:0]        loss_d;

  always_comb begin
    acc_sum = acc_q + 64'(prod_q);
    if (acc_sum > DOT_LIM) begin
      acc_d = DOT_LIM;
    end else if (acc_sum < -DOT_LIM) begin
      acc_d = -DOT_LIM;
    end else begin
      acc_d = acc_sum;
    end
    ssum = (acc_q >>> 12) + 64'(gb_q) + 64'(ub_q) + 64'(ib_q);
    if (ssum > SCORE_LIM) begin
      sclamp = SCORE_LIM;
    end else if (ssum < -SCORE_LIM) begin
      sclamp = -SCORE_LIM;
    end else begin
      sclamp = ssum;
    end
    score_d = 42'(sclamp);

    a    = score_q[41] ? 41'(-score_q) : 41'(score_q);
    sigv = lmf_pkg::interp(1'b0, a);
    lsev = lmf_pkg::interp(1'b1, a);
    sg   = score_q[41] ? (17'd65536 - 17'(sigv)) : 17'(sigv);
    g_d  = (label_q ? lmf_pkg::GW'(65536) : lmf_pkg::GW'(0)) - $signed(lmf_pkg::GW'(sg));
    // |z| equals |score|, so the softplus lookup shares a with the sigmoid lookup
    z     = label_q ? -score_q : score_q;
    part1 = (!z[41] && (z != '0)) ? z[41:4] : '0;
    lsum  = 39'(part1) + 39'(lsev[15:8]);
    loss_d = (lsum > 39'd65535) ? 16'hFFFF : lsum[15:0];
  end

  // --------------------------------------------------------------------------
  // update lanes: one for the user row and global bias, one for the item row
  // --------------------------------------------------------------------------
  always_comb begin
    lane_v = rv_q && rupd_q;
    ul_x   = (rk_q == K_GLOB) ? gb_q : u_rdata;
    ul_oth = (rk_q >= K_BIAS) ? BIAS_OTHER : OTW'(i_rdata);
    il_x   = i_rdata;
    il_oth = (rk_q >= K_BIAS) ? BIAS_OTHER : OTW'(u_rdata);
  end

  lmf_upd #(.VW(VW), .OTW(OTW), .TW(CW)) u_user_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lane_v),
    .tag_i   (rk_q),
    .x_i     (ul_x),
    .other_i (ul_oth),
    .grad_i  (g_q),
    .rate_i  (rate_q),
    .decay_i (decay_q),
    .valid_o (ul_ov),
    .tag_o   (ul_tag),
    .x_o     (ul_new),
    .busy_o  (ul_busy)
  );

  lmf_upd #(.VW(VW), .OTW(OTW), .TW(CW)) u_item_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lane_v),
    .tag_i   (rk_q),
    .x_i     (il_x),
    .other_i (il_oth),
    .grad_i  (g_q),
    .rate_i  (rate_q),
    .decay_i (decay_q),
    .valid_o (il_ov),
    .tag_o   (il_tag),
    .x_o     (il_new),
    .busy_o  (il_busy)
  );

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmf_pkg::ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      rv_q        <= 1'b0;
      rupd_q      <= 1'b0;
      mv_q        <= 1'b0;
      gb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lmf_pkg::ST_CLEAR) clr_q <= clr_q + CLW'(1);
      if (state_q == lmf_pkg::ST_EXEC || state_q == lmf_pkg::ST_SIG) begin
        k_q <= '0;
      end else if (rd_issue) begin
        k_q <= k_q + CW'(1);
      end
      rv_q   <= rd_issue;
      rupd_q <= (state_q == lmf_pkg::ST_UPD_RD);
      mv_q   <= rv_q && !rupd_q && (rk_q < K_BIAS);
      if (state_q == lmf_pkg::ST_EXEC && op_q == lmf_pkg::OP_WR_GLOBAL) begin
        gb_q <= wsat_q;
      end else if (ul_ov && ul_tag == K_GLOB) begin
        gb_q <= ul_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_d;
      ubase_q <= UAW'(32'(user_index_i) * ROW);
      ibase_q <= IAW'(32'(item_index_i) * ROW);
      label_q <= label_i;
      elem_q  <= CW'(element_index_i);
      wsat_q  <= wsat_d;
    end
    rk_q <= k_q;
    if (rv_q && !rupd_q && (rk_q < K_BIAS)) prod_q <= u_rdata * i_rdata;
    if (rv_q && !rupd_q && (rk_q == K_BIAS)) begin
      ub_q <= u_rdata;
      ib_q <= i_rdata;
    end
    if (state_q == lmf_pkg::ST_EXEC) begin
      acc_q <= '0;
    end else if (mv_q) begin
      acc_q <= acc_d;
    end
    if (state_q == lmf_pkg::ST_SCORE) score_q <= score_d;
    if (state_q == lmf_pkg::ST_EXEC) begin
      res_loss_q <= '0;
      res_rv_q   <= (op_q == lmf_pkg::OP_RD_GLOBAL) ? 16'(gb_q) : '0;
    end else if (state_q == lmf_pkg::ST_SIG) begin
      g_q        <= g_d;
      res_loss_q <= loss_d;
    end else if (state_q == lmf_pkg::ST_RDWAIT) begin
      res_rv_q <= (op_q == lmf_pkg::OP_RD_USER) ? 16'(u_rdata) : 16'(i_rdata);
    end
    if (load_out) begin
      out_loss_q <= res_loss_q;
      out_rv_q   <= res_rv_q;
    end
  end

  assign in_stall_o   = (state_q != lmf_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign loss_o       = out_loss_q;
  assign read_value_o = out_rv_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_write_in_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lmf_pkg::ST_DOT_RD || state_q == lmf_pkg::ST_DOT_WAIT) |-> !u_we && !i_we)
    else $error("RAM write during dot product walk");

  a_lane_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ul_ov |-> (state_q == lmf_pkg::ST_UPD_RD || state_q == lmf_pkg::ST_UPD_DRAIN))
    else $error("update lane result outside update phase");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == lmf_pkg::ST_EXEC)
    else $error("accepted command not dispatched");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lmf_pkg::ST_CLEAR) |-> !out_valid_o && in_stall_o)
    else $error("channel active during bias clearing");

endmodule

// ----- tb/logistic_mf_sgd_update_test.sv -----
// ----------------------------------------------------------------------------
// logistic_mf_sgd_update_test: self-checking bench for the SGD update engine
// Drives commands through the valid/stall channel, keeps its own copy of the
// factor tables and biases, predicts loss and read values, and compares every
// result transfer in order. Runs several learning-rate / decay settings with
// changing idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module logistic_mf_sgd_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [4:0] BIAS_ELEM  = 5'd16;
  localparam int         DIM        = 16;
  localparam longint     CYCLE_LIMIT = 3000000;
  localparam int         HOLD_CYCLES = 400;

  // interpolation tables, Q0.16, half-unit steps
  localparam int SIGMOID_TAB [17] = '{32768, 40793, 47910, 53581, 57724, 60565,
    62428, 63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
  localparam int SOFTPLUS_TAB [17] = '{45426, 31069, 20530, 13200, 8318, 5170,
    3184, 1950, 1189, 724, 440, 267, 162, 98, 60, 36, 22};

  typedef struct packed {
    logic [2:0]         command;
    logic [11:0]        user;
    logic [11:0]        item;
    logic               label;
    logic [4:0]         elem;
    logic signed [15:0] wval;
  } cmd_t;

  typedef struct packed {
    logic [15:0] loss;
    logic [15:0] rd;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = '0;
  logic [11:0] user_index_i = '0, item_index_i = '0;
  logic label_i = 1'b0;
  logic [4:0] element_index_i = '0;
  logic signed [15:0] write_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] loss_o;
  logic signed [15:0] read_value_o;

  logistic_mf_sgd_update u_dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  int   user_tab [65536];
  int   item_tab [65536];
  int   user_bias [4096];
  int   item_bias [4096];
  int   glob_bias;
  bit   user_set [65536];
  bit   item_set [65536];
  longint rate = 655;
  longint decay = 0;

  cmd_t    pending_cmds [$];
  answer_t expected_answers [$];

  int tx_idle_pct, rx_idle_pct;
  int hold_req, hold_served, hold_left;
  bit in_fire;
  int n_in, n_out, n_train, n_bad;
  longint cycles;

  int user_pool [4] = '{0, 1, 2, 4095};
  int item_pool [4] = '{0, 1, 2, 4095};

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clampl(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint lookup(bit softplus, longint a);
    longint k, f, t0, t1;
    if (a >= 32768) return softplus ? SOFTPLUS_TAB[16] : SIGMOID_TAB[16];
    k  = a >>> 11;
    f  = a & 2047;
    t0 = softplus ? SOFTPLUS_TAB[k] : SIGMOID_TAB[k];
    t1 = softplus ? SOFTPLUS_TAB[k+1] : SIGMOID_TAB[k+1];
    return (t0 * (2048 - f) + t1 * f) >>> 11;
  endfunction

  // one regularised SGD step, rounded to nearest, ties up
  function automatic int sgd_step(longint x, longint g, longint other);
    longint diff, hi, lo, b;
    diff = g * other - decay * x;
    hi = diff >>> 16;
    lo = diff - hi * 65536;
    b  = lo * rate + (longint'(1) << 31);
    return int'(sat16(x + ((hi * rate + (b >>> 16)) >>> 16)));
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t r;
    longint dot, score, sg, z, lv, g, a;
    int pu [DIM];
    int qi [DIM];
    int ubase, ibase, slot;
    bit isb;
    r = '0;
    ubase = int'(c.user) * DIM;
    ibase = int'(c.item) * DIM;
    isb = c.elem == BIAS_ELEM;
    case (c.command)
      lmf_pkg::CMD_TRAIN: begin
        dot = 0;
        for (int k = 0; k < DIM; k++) begin
          pu[k] = user_tab[ubase+k];
          qi[k] = item_tab[ibase+k];
          dot = clampl(dot + longint'(pu[k]) * longint'(qi[k]), longint'(1) << 61);
        end
        score = (dot >>> 12) + glob_bias + user_bias[c.user] + item_bias[c.item];
        score = clampl(score, longint'(1) << 40);
        a = score < 0 ? -score : score;
        sg = lookup(1'b0, a);
        if (score < 0) sg = 65536 - sg;
        z = c.label ? -score : score;
        lv = (z > 0 ? (z >>> 4) : 0) + (lookup(1'b1, z < 0 ? -z : z) >>> 8);
        if (lv > 65535) lv = 65535;
        r.loss = lv[15:0];
        g = (c.label ? 65536 : 0) - sg;
        for (int k = 0; k < DIM; k++) begin
          user_tab[ubase+k] = sgd_step(pu[k], g, qi[k]);
          item_tab[ibase+k] = sgd_step(qi[k], g, pu[k]);
        end
        user_bias[c.user] = sgd_step(user_bias[c.user], g, 4096);
        item_bias[c.item] = sgd_step(item_bias[c.item], g, 4096);
        glob_bias = sgd_step(glob_bias, g, 4096);
      end
      lmf_pkg::CMD_WR_USER, lmf_pkg::CMD_RD_USER: if (c.elem <= BIAS_ELEM) begin
        slot = ubase + int'(c.elem);
        if (c.command == lmf_pkg::CMD_WR_USER) begin
          if (isb) user_bias[c.user] = c.wval;
          else user_tab[slot] = c.wval;
        end else begin
          r.rd = isb ? 16'(user_bias[c.user]) : 16'(user_tab[slot]);
        end
      end
      lmf_pkg::CMD_WR_ITEM, lmf_pkg::CMD_RD_ITEM: if (c.elem <= BIAS_ELEM) begin
        slot = ibase + int'(c.elem);
        if (c.command == lmf_pkg::CMD_WR_ITEM) begin
          if (isb) item_bias[c.item] = c.wval;
          else item_tab[slot] = c.wval;
        end else begin
          r.rd = isb ? 16'(item_bias[c.item]) : 16'(item_tab[slot]);
        end
      end
      lmf_pkg::CMD_WR_GLOBAL: glob_bias = c.wval;
      lmf_pkg::CMD_RD_GLOBAL: r.rd = 16'(glob_bias);
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, int u, int it, bit y, int e, int w);
    cmd_t c;
    c.command = op;
    c.user    = 12'(u);
    c.item    = 12'(it);
    c.label   = y;
    c.elem    = 5'(e);
    c.wval    = 16'(w);
    return c;
  endfunction

  // queue a command; entry-written flags are tracked at generation time
  task automatic push_cmd(cmd_t c);
    if (c.elem < BIAS_ELEM) begin
      if (c.command == lmf_pkg::CMD_WR_USER) user_set[int'(c.user)*DIM + int'(c.elem)] = 1'b1;
      if (c.command == lmf_pkg::CMD_WR_ITEM) item_set[int'(c.item)*DIM + int'(c.elem)] = 1'b1;
    end
    pending_cmds.push_back(c);
  endtask

  function automatic int rand_value();
    case ($urandom_range(3))
      0:       return $urandom_range(65535) - 32768;
      1:       return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  task automatic push_random();
    int sel, u, it, e;
    cmd_t c;
    sel = $urandom_range(99);
    u  = $urandom_range(4095);
    it = $urandom_range(4095);
    e  = $urandom_range(15);
    c = make_cmd(lmf_pkg::CMD_TRAIN, user_pool[$urandom_range(3)],
                 item_pool[$urandom_range(3)],
                 $urandom_range(1), $urandom_range(31), $urandom_range(65535));
    if (sel < 45) begin
      // train on fully written rows, other fields left random
    end else if (sel < 55) begin
      c = make_cmd($urandom_range(1) ? lmf_pkg::CMD_WR_USER : lmf_pkg::CMD_WR_ITEM, u, it,
                   $urandom_range(1), e, rand_value());
    end else if (sel < 62) begin
      c.command = $urandom_range(1) ? lmf_pkg::CMD_WR_USER : lmf_pkg::CMD_WR_ITEM;
      c.elem = BIAS_ELEM;
      c.wval = 16'(rand_value());
    end else if (sel < 75) begin
      // read: factor entry if written, else that row's bias
      c = make_cmd($urandom_range(1) ? lmf_pkg::CMD_RD_USER : lmf_pkg::CMD_RD_ITEM, u, it,
                   $urandom_range(1), e, $urandom_range(65535));
      if (c.command == lmf_pkg::CMD_RD_USER && !user_set[u*DIM+e]) c.elem = BIAS_ELEM;
      if (c.command == lmf_pkg::CMD_RD_ITEM && !item_set[it*DIM+e]) c.elem = BIAS_ELEM;
    end else if (sel < 82) begin
      c = make_cmd(lmf_pkg::CMD_WR_GLOBAL, u, it, $urandom_range(1), $urandom_range(31),
                   $urandom_range(3) == 0 ? rand_value() : int'($urandom_range(2047)) - 1024);
    end else if (sel < 90) begin
      c = make_cmd(lmf_pkg::CMD_RD_GLOBAL, u, it, $urandom_range(1), $urandom_range(31),
                   $urandom_range(65535));
    end else if (sel < 95) begin
      c = make_cmd(CMD_UNUSED, u, it, $urandom_range(1), $urandom_range(31),
                   $urandom_range(65535));
    end else begin
      // element past the row bias: no effect
      c = make_cmd(3'($urandom_range(1, 4)), u, it, $urandom_range(1),
                   $urandom_range(17, 31), $urandom_range(65535));
    end
    push_cmd(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_answers.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == lmf_pkg::CFG_RATE) rate = data[15:0];
    else decay = data[15:0];
  endtask

  task automatic set_rates(int lr, int lam);
    wait_drained();
    apb_write(3'({lmf_pkg::CFG_RATE, 2'b00}), 32'(lr));
    apb_write(3'({lmf_pkg::CFG_DECAY, 2'b00}), 32'(lam));
  endtask

  // --------------------------------------------------------------------------
  // Sender: holds an offered transfer until it is taken, otherwise offers the
  // next queued command unless this cycle is picked as an idle one.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_fire)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i      <= 1'b1;
        command_i       <= pending_cmds[0].command;
        user_index_i    <= pending_cmds[0].user;
        item_index_i    <= pending_cmds[0].item;
        label_i         <= pending_cmds[0].label;
        element_index_i <= pending_cmds[0].elem;
        write_value_i   <= pending_cmds[0].wval;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_served) begin
      hold_served <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < rx_idle_pct;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: an input transfer runs the predictor, a result transfer is
  // checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    answer_t want;
    cycles++;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      if (pending_cmds[0].command == lmf_pkg::CMD_TRAIN) n_train++;
      expected_answers.push_back(predict_answer(pending_cmds.pop_front()));
      n_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (expected_answers.size() == 0) begin
        $error("result transfer with nothing expected");
        n_bad++;
      end else begin
        want = expected_answers.pop_front();
        if (loss_o !== want.loss) begin
          $error("loss: expected %0d, got %0d", want.loss, loss_o);
          n_bad++;
        end
        if (read_value_o !== want.rd) begin
          $error("read_value: expected %0d, got %0d",
                 $signed(want.rd), read_value_o);
          n_bad++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    tx_idle_pct = 10;
    rx_idle_pct = 81;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every factor entry of the training rows
    foreach (user_pool[i])
      for (int k = 0; k < DIM; k++)
        push_cmd(make_cmd(lmf_pkg::CMD_WR_USER, user_pool[i], 0, 0, k,
                          int'($urandom_range(4095)) - 2048));
    foreach (item_pool[i])
      for (int k = 0; k < DIM; k++)
        push_cmd(make_cmd(lmf_pkg::CMD_WR_ITEM, 0, item_pool[i], 0, k,
                          int'($urandom_range(4095)) - 2048));

    // directed: extremes, every command, unused code, element out of range
    push_cmd(make_cmd(lmf_pkg::CMD_WR_GLOBAL, 4095, 4095, 1, 31, 32767));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_GLOBAL, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_WR_USER, 0, 0, 0, BIAS_ELEM, -32768));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_USER, 0, 4095, 1, BIAS_ELEM, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_WR_ITEM, 4095, 4095, 0, 15, 32767));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_ITEM, 0, 4095, 0, 15, -1));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_USER, 4095, 0, 0, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_TRAIN, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_TRAIN, 0, 0, 1, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_TRAIN, 4095, 4095, 1, 31, -32768));
    push_cmd(make_cmd(lmf_pkg::CMD_TRAIN, 4095, 4095, 0, 16, 32767));
    push_cmd(make_cmd(CMD_UNUSED, 4095, 4095, 1, 31, -1));
    push_cmd(make_cmd(lmf_pkg::CMD_WR_USER, 1, 1, 0, 17, 1234));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_USER, 1, 1, 0, 17, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_WR_ITEM, 2, 2, 0, 31, -1234));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_ITEM, 2, 2, 0, 31, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_WR_GLOBAL, 0, 0, 0, 0, -32768));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_GLOBAL, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_TRAIN, 1, 2, 1, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_WR_GLOBAL, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_USER, 4095, 0, 0, BIAS_ELEM, 0));
    push_cmd(make_cmd(lmf_pkg::CMD_RD_ITEM, 0, 0, 0, BIAS_ELEM, 0));
    repeat (400) push_random();

    // fastest steps with heaviest decay, sender mostly idle
    set_rates(65535, 65535);
    tx_idle_pct = 81;
    rx_idle_pct = 10;
    repeat (400) push_random();

    // no learning, full decay setting; no idling and one long hold-off
    set_rates(0, 65535);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1;
    repeat (400) push_random();

    // moderate random settings
    set_rates($urandom_range(1, 8000), $urandom_range(0, 2000));
    tx_idle_pct = 10;
    rx_idle_pct = 81;
    repeat (400) push_random();

    wait_drained();
    $display("%0d commands sent (%0d trains) over four rate settings, %0d results compared",
             n_in, n_train, n_out);
    $display("%0d mismatches, %0d predictions left over", n_bad, expected_answers.size());
    if (n_bad == 0 && expected_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
